@@ src/rsom_pkg.sv @@
// Package: shared types and constants for the ring SOM training block.
`default_nettype none
package rsom_pkg;
	localparam int COMP_W  = 16;
	localparam int SCORE_W = 34;
	localparam int PROD_W  = 32;
	localparam int LANES   = 4;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_TRAIN = 1'b1;

	localparam logic signed [9:0] H_NEAR = 10'sd154;
	localparam logic signed [9:0] H_ONE  = 10'sd51;
	localparam logic signed [9:0] H_TWO  = -10'sd128;

	typedef logic signed [COMP_W-1:0] comp_t;

	// one lane's update request
	typedef struct packed {
		logic signed [COMP_W-1:0] w;
		logic signed [COMP_W-1:0] x;
		logic [COMP_W-1:0]        rate;
		logic signed [9:0]        h;
	} upd_in_t;
endpackage
`default_nettype wire

@@ src/rsom_lane.sv @@
// One lane: product for scoring, and a pipelined weight update.
`default_nettype none
module rsom_lane
	import rsom_pkg::*;
(
	input  wire logic                       clk,
	input  wire upd_in_t                    upd,
	output logic signed [PROD_W-1:0]        prod,
	output logic signed [COMP_W-1:0]        new_w
);
	logic signed [COMP_W:0]     diff_s1;
	logic signed [9:0]          h_s1;
	logic [COMP_W-1:0]          rate_s1;
	logic signed [COMP_W-1:0]   w_s1, w_s2;
	logic signed [27:0]         dh_s2;
	logic [COMP_W-1:0]          rate_s2;
	logic signed [45:0]         prod_full;
	logic signed [21:0]         delta;
	logic signed [22:0]         sum;

	// score product is combinational on the lane's inputs, registered in the top level before the merge
	assign prod = PROD_W'(upd.w * upd.x);

	always_ff @(posedge clk) begin
		diff_s1 <= (COMP_W+1)'(upd.x) - (COMP_W+1)'(upd.w);
		h_s1    <= upd.h;
		rate_s1 <= upd.rate;
		w_s1    <= upd.w;
		dh_s2   <= 28'(diff_s1 * h_s1);
		rate_s2 <= rate_s1;
		w_s2    <= w_s1;
	end

	assign prod_full = 46'(dh_s2 * $signed({1'b0, rate_s2}));
	assign delta = prod_full[45:24];
	assign sum   = 23'(w_s2) + 23'(delta);

	always_comb begin
		if (sum > 23'sd32767)       new_w = 16'sh7fff;
		else if (sum < -23'sd32768) new_w = 16'sh8000;
		else                        new_w = sum[COMP_W-1:0];
	end
endmodule
`default_nettype wire

@@ src/ring_som_train_step.sv @@
// Top level: ring SOM with four component lanes, score pass then update pass.
//
//  channel  | handshake       | payload
//  ---------+-----------------+--------------------------------------------
//  request  | in_valid/ready  | req_type neuron_index comp0..3 learn_rate
//  result   | out_valid/ready | winner_index winner_score
//
// A load returns its result the cycle after acceptance. In a train, one neuron
// is read from the weight memory per cycle in the scoring pass and again in the
// update pass, the four lanes covering the four components. The update pass
// runs each neuron through the read-data register and the lane's s1 and s2
// registers before write-back. Reset clears control only; weights are undefined
// until loaded. A result held by the receiver stalls the next request.
`default_nettype none
module ring_som_train_step
	import rsom_pkg::*;
#(
	parameter int NUM_NEURONS = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      req_type,
	input  wire logic [3:0]                neuron_index,
	input  wire logic signed [COMP_W-1:0]  comp0,
	input  wire logic signed [COMP_W-1:0]  comp1,
	input  wire logic signed [COMP_W-1:0]  comp2,
	input  wire logic signed [COMP_W-1:0]  comp3,
	input  wire logic [COMP_W-1:0]         learn_rate,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [3:0]                     winner_index,
	output logic signed [SCORE_W-1:0]      winner_score
);
	localparam int IW = $clog2(NUM_NEURONS);
	localparam int CW = IW + 1;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCORE = 3'd1;
	localparam logic [2:0] ST_UPD   = 3'd2;
	localparam logic [2:0] ST_DONE  = 3'd3;

	logic [2:0]          state_q;
	logic [CW-1:0]       rd_cnt_q;
	logic                rd_vld_s1, rd_vld_s2, rd_vld_s3;
	logic                rd_upd_s1, rd_upd_s2, rd_upd_s3;
	logic [IW-1:0]       rd_idx_s1, rd_idx_s2, rd_idx_s3;
	logic [CW-1:0]       wr_cnt_q;
	comp_t               x_q [LANES];
	logic [COMP_W-1:0]   rate_q;
	logic [IW-1:0]       win_q;
	logic signed [SCORE_W-1:0] best_q;
	logic                first_q;
	logic [SCORE_W*LANES-1:0] mem [NUM_NEURONS];
	logic [SCORE_W*LANES-1:0] rd_data_s1;
	logic signed [PROD_W-1:0] prod [LANES];
	logic signed [PROD_W-1:0] prod_s2 [LANES];
	logic signed [COMP_W-1:0] new_w [LANES];
	logic signed [SCORE_W-1:0] score;
	logic [IW-1:0]       ring_dist, dist_a, dist_b;
	logic signed [9:0]   h;
	logic                res_pend_q;
	logic [3:0]          res_idx_q;
	logic signed [SCORE_W-1:0] res_score_q;
	logic                accept, res_set;

	assign accept  = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE) && !(out_valid && !out_ready);
	assign res_set = (state_q == ST_DONE) || (accept && req_type == REQ_LOAD);

	// ring distance to the winner for the neuron in the lanes
	assign dist_a = rd_idx_s1 > win_q ? rd_idx_s1 - win_q : win_q - rd_idx_s1;
	assign dist_b = IW'(NUM_NEURONS - 32'(dist_a));
	assign ring_dist = (dist_b < dist_a) ? dist_b : dist_a;
	always_comb begin
		case (ring_dist)
			IW'(0):  h = H_NEAR;
			IW'(1):  h = H_ONE;
			IW'(2):  h = H_TWO;
			default: h = '0;
		endcase
	end

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		upd_in_t u;
		assign u.w    = rd_data_s1[l*SCORE_W +: COMP_W];
		assign u.x    = x_q[l];
		assign u.rate = rate_q;
		assign u.h    = h;
		rsom_lane u_lane (.clk(clk), .upd(u), .prod(prod[l]), .new_w(new_w[l]));
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s3 && rd_upd_s3)
			mem[rd_idx_s3] <= {
				SCORE_W'(new_w[3]), SCORE_W'(new_w[2]),
				SCORE_W'(new_w[1]), SCORE_W'(new_w[0])};
		else if (accept && req_type == REQ_LOAD && 32'(neuron_index) < NUM_NEURONS)
			mem[IW'(neuron_index)] <= {
				SCORE_W'(comp3), SCORE_W'(comp2), SCORE_W'(comp1), SCORE_W'(comp0)};
		rd_data_s1 <= mem[rd_cnt_q[IW-1:0]];
		for (int l = 0; l < LANES; l++) prod_s2[l] <= prod[l];
		if (accept) begin
			x_q[0] <= comp0; x_q[1] <= comp1; x_q[2] <= comp2; x_q[3] <= comp3;
			rate_q <= learn_rate;
		end
	end

	assign score = SCORE_W'(prod_s2[0]) + SCORE_W'(prod_s2[1])
	             + SCORE_W'(prod_s2[2]) + SCORE_W'(prod_s2[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE; rd_cnt_q <= '0; wr_cnt_q <= '0;
			rd_vld_s1 <= 1'b0; rd_vld_s2 <= 1'b0; rd_vld_s3 <= 1'b0;
			rd_upd_s1 <= 1'b0; rd_upd_s2 <= 1'b0; rd_upd_s3 <= 1'b0;
			rd_idx_s1 <= '0; rd_idx_s2 <= '0; rd_idx_s3 <= '0;
			win_q <= '0; best_q <= '0; first_q <= 1'b0;
			res_pend_q <= 1'b0; res_idx_q <= '0; res_score_q <= '0;
		end else begin
			if (res_set) res_pend_q <= 1'b1;
			else if (out_valid && out_ready) res_pend_q <= 1'b0;
			rd_vld_s1 <= (state_q == ST_SCORE || state_q == ST_UPD)
			           && rd_cnt_q < CW'(NUM_NEURONS);
			// tag reads of the update pass so scoring leftovers are never written
			rd_upd_s1 <= (state_q == ST_UPD);
			rd_idx_s1 <= rd_cnt_q[IW-1:0];
			rd_vld_s2 <= rd_vld_s1; rd_upd_s2 <= rd_upd_s1; rd_idx_s2 <= rd_idx_s1;
			rd_vld_s3 <= rd_vld_s2; rd_upd_s3 <= rd_upd_s2; rd_idx_s3 <= rd_idx_s2;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_cnt_q <= '0;
						wr_cnt_q <= '0;
						first_q  <= 1'b1;
						if (req_type == REQ_TRAIN) begin
							state_q <= ST_SCORE;
						end else begin
							res_idx_q <= '0; res_score_q <= '0;
						end
					end
				end
				ST_SCORE: begin
					// merge: strict greater wins, so earlier index holds ties
					if (rd_vld_s2) begin
						first_q <= 1'b0;
						if (first_q || score > best_q) begin
							best_q <= score;
							win_q  <= rd_idx_s2;
						end
					end
					if (rd_vld_s2 && rd_idx_s2 == IW'(NUM_NEURONS - 1)) begin
						state_q  <= ST_UPD;
						rd_cnt_q <= '0;
					end else if (rd_cnt_q < CW'(NUM_NEURONS)) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_UPD: begin
					if (rd_cnt_q < CW'(NUM_NEURONS)) rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_vld_s3 && rd_upd_s3) begin
						wr_cnt_q <= wr_cnt_q + 1'b1;
						if (rd_idx_s3 == IW'(NUM_NEURONS - 1)) state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					res_idx_q   <= 4'(win_q);
					res_score_q <= best_q;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid    = res_pend_q;
	assign winner_index = res_idx_q;
	assign winner_score = res_score_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("request taken while busy");
	a_wr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> (wr_cnt_q == CW'(NUM_NEURONS)))
		else $error("update pass lost a neuron");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(winner_score)))
		else $error("result dropped while stalled");
endmodule
`default_nettype wire
